// ----- rtl/lpht_pkg.sv -----
// Shared types, constants and hash coefficients for the linear-probing hash table.
// No dependencies; imported by lpht_ram users and the top level.
package lpht_pkg;

  // Table depth must be a power of two: the probe start is the low hash bits.
  localparam int SLOTS         = 256;
  localparam int IDX_W         = $clog2(SLOTS);
  localparam int CNT_W         = $clog2(SLOTS + 1);
  localparam int KEY_MAX_BYTES = 8;
  localparam int KEY_W         = 64;
  localparam int LEN_W         = 4;
  localparam int HASH_W        = 32;
  localparam int VAL_W         = 32;
  localparam int LOAD_MAX      = (3 * SLOTS) / 4;

  localparam logic [63:0] HASH_SEED = 64'd2166136261;
  localparam logic [63:0] MUL_BLOCK = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MUL_TAIL  = 64'hd6e8feb86659fd93;
  localparam logic [63:0] MUL_ONE   = 64'd1;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic {
    OP_SET = 1'b0,
    OP_GET = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_ADD,
    S_FOLD,
    S_PROBE
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [LEN_W-1:0]  len;
    logic [HASH_W-1:0] hash;
    logic [VAL_W-1:0]  value;
  } slot_t;

endpackage

// ----- rtl/lpht_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module lpht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/linear_probe_hash_table_core.sv -----
// Open-addressing key/value table with linear probing and fixed capacity.
// Depends on lpht_pkg and lpht_ram.
//
// Each word on the input is a set or a get of a key of up to eight bytes. The key is
// hashed by a multiply-xor hash whose 64-bit product is built from three 32x32
// partial products on one shared multiplier; hashing runs through S_MUL0, S_MUL1,
// S_MUL2, S_ADD and S_FOLD. Probing then reads the slot RAM one entry per cycle
// starting at the low hash bits until a hit, an empty slot or the last of at most
// SLOTS probed slots; the next word is taken once the result word is registered
// and the state machine is back in idle. A result waits in an output register, so
// a new item is taken while the previous result is still unread. Valid marks live
// in flip-flops cleared by reset; no clearing pass is needed. Inserts beyond three
// quarters load are rejected.
module linear_probe_hash_table_core
  import lpht_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_opcode,
  input  logic [KEY_W-1:0]    in_key_bytes,
  input  logic [LEN_W-1:0]    in_key_len,
  input  logic [VAL_W-1:0]    in_value_in,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_status,
  output logic [VAL_W-1:0]    out_value_out
);

  state_t             state_r, state_nxt;
  logic               op_r, op_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [VAL_W-1:0]   val_r, val_nxt;
  logic [63:0]        x_r, x_nxt;
  logic [63:0]        m_r, m_nxt;
  logic [63:0]        prod_r, prod_nxt;
  logic [63:0]        acc_r, acc_nxt;
  logic [HASH_W-1:0]  hash_r, hash_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [IDX_W-1:0]   probe_n_r, probe_n_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [SLOTS-1:0]   valid_r, valid_nxt;
  logic               out_valid_r, out_valid_nxt;
  status_t            status_r, status_nxt;
  logic [VAL_W-1:0]   vout_r, vout_nxt;

  logic [LEN_W-1:0]   sat_len;
  logic [KEY_W-1:0]   key_m;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mul_p;
  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [$bits(slot_t)-1:0] ram_rdata;
  slot_t              slot_rd, slot_wr;
  logic               hit, empty, last, term, done;

  lpht_ram #(
    .WIDTH($bits(slot_t)),
    .DEPTH(SLOTS)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(idx_r),
    .wdata(slot_wr),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_value_out = vout_r;

  assign slot_rd = slot_t'(ram_rdata);
  assign slot_wr = '{key: key_r, len: len_r, hash: hash_r, value: val_r};

  // The one 32x32 multiplier, fed by the state machine.
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // Length saturation and masking of unused key bytes at acceptance.
  always_comb begin
    sat_len = (in_key_len > LEN_W'(KEY_MAX_BYTES)) ? LEN_W'(KEY_MAX_BYTES) : in_key_len;
    for (int b = 0; b < 8; b++) begin
      key_m[8*b +: 8] = (LEN_W'(b) < sat_len) ? in_key_bytes[8*b +: 8] : 8'h00;
    end
  end

  assign hit   = valid_r[idx_r] && (slot_rd.len == len_r) && (slot_rd.hash == hash_r) &&
                 (slot_rd.key == key_r);
  assign empty = !valid_r[idx_r];
  assign last  = (probe_n_r == {IDX_W{1'b1}});
  assign term  = hit || empty || last;
  assign done  = (state_r == S_PROBE) && term && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    len_nxt       = len_r;
    val_nxt       = val_r;
    x_nxt         = x_r;
    m_nxt         = m_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    hash_nxt      = hash_r;
    idx_nxt       = idx_r;
    probe_n_nxt   = probe_n_r;
    count_nxt     = count_r;
    valid_nxt     = valid_r;
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt    = status_r;
    vout_nxt      = vout_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = idx_r;
    mul_a         = x_r[31:0];
    mul_b         = m_r[31:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt  = in_opcode;
          key_nxt = key_m;
          len_nxt = sat_len;
          val_nxt = in_value_in;
          // An empty key multiplies the seed by one, leaving it unchanged.
          if (sat_len == LEN_W'(KEY_MAX_BYTES)) begin
            x_nxt = HASH_SEED ^ key_m;
            m_nxt = MUL_BLOCK;
          end else if (sat_len == '0) begin
            x_nxt = HASH_SEED;
            m_nxt = MUL_ONE;
          end else begin
            x_nxt = HASH_SEED ^ {key_m[55:0], 4'h0, sat_len};
            m_nxt = MUL_TAIL;
          end
          state_nxt = S_MUL0;
        end
      end
      S_MUL0: begin
        mul_a     = x_r[31:0];
        mul_b     = m_r[31:0];
        prod_nxt  = mul_p;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        mul_a     = x_r[31:0];
        mul_b     = m_r[63:32];
        acc_nxt   = prod_r;
        prod_nxt  = mul_p;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        mul_a     = x_r[63:32];
        mul_b     = m_r[31:0];
        acc_nxt   = acc_r + {prod_r[31:0], 32'h0};
        prod_nxt  = mul_p;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        acc_nxt   = acc_r + {prod_r[31:0], 32'h0};
        state_nxt = S_FOLD;
      end
      S_FOLD: begin
        hash_nxt    = acc_r[63:32] ^ acc_r[31:0];
        idx_nxt     = hash_nxt[IDX_W-1:0];
        probe_n_nxt = '0;
        ram_re      = 1'b1;
        ram_raddr   = idx_nxt;
        state_nxt   = S_PROBE;
      end
      S_PROBE: begin
        if (!term) begin
          idx_nxt     = idx_r + 1'b1;
          probe_n_nxt = probe_n_r + 1'b1;
          ram_re      = 1'b1;
          ram_raddr   = idx_nxt;
        end else if (done) begin
          out_valid_nxt = 1'b1;
          vout_nxt      = '0;
          state_nxt     = S_IDLE;
          if (op_r == OP_GET) begin
            if (hit) begin
              status_nxt = ST_FOUND;
              vout_nxt   = slot_rd.value;
            end else begin
              status_nxt = ST_NOT_FOUND;
            end
          end else if (hit) begin
            // Key, length and hash equal the stored ones, so the whole entry is rewritten.
            ram_we     = 1'b1;
            status_nxt = ST_UPDATED;
          end else if (!empty || (count_r >= CNT_W'(LOAD_MAX))) begin
            status_nxt = ST_FULL;
          end else begin
            ram_we           = 1'b1;
            valid_nxt[idx_r] = 1'b1;
            count_nxt        = count_r + 1'b1;
            status_nxt       = ST_INSERTED;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    key_r     <= key_nxt;
    len_r     <= len_nxt;
    val_r     <= val_nxt;
    x_r       <= x_nxt;
    m_r       <= m_nxt;
    prod_r    <= prod_nxt;
    acc_r     <= acc_nxt;
    hash_r    <= hash_nxt;
    idx_r     <= idx_nxt;
    probe_n_r <= probe_n_nxt;
    status_r  <= status_nxt;
    vout_r    <= vout_nxt;
  end

  // The entry count never passes the load limit.
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CNT_W'(LOAD_MAX))
    else $error("entry count above load limit");

  // A nonzero value word is only ever a found result.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (vout_r != '0) |-> status_r == ST_FOUND)
    else $error("value word nonzero on a result other than found");

  // The count moves only together with an inserted result.
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (count_r != $past(count_r)) |->
      out_valid_r && (status_r == ST_INSERTED) && (count_r == $past(count_r) + 1'b1))
    else $error("entry count changed without an insert");

  // An accepted word always starts the hash sequence.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_MUL0)
    else $error("accepted word did not start hashing");

  // A result is never overwritten while it still waits.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(status_r) && $stable(vout_r))
    else $error("pending result word lost");

endmodule
